// File: rtl/dsv_pkg.sv
package dsv_pkg;

    localparam int CH_W    = 8;
    localparam int DAY_W   = 7;
    localparam int MONTH_W = 7;
    localparam int YEAR_W  = 14;
    localparam int POS_W   = 4;

    localparam logic [CH_W-1:0]  CH_DOT   = 8'h2E;
    localparam logic [CH_W-1:0]  CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0]  CH_NINE  = 8'h39;

    localparam logic [POS_W-1:0] POS_DAY_END   = 4'd2;   // dot slot after day
    localparam logic [POS_W-1:0] POS_MONTH_END = 4'd5;   // dot slot after month
    localparam logic [POS_W-1:0] POS_YY_LO     = 4'd8;   // first low-year digit
    localparam logic [POS_W-1:0] STRING_LEN    = 4'd10;
    localparam logic [POS_W-1:0] POS_SAT       = 4'd11;

    localparam logic [MONTH_W-1:0] MONTH_FEB = 7'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAX = 7'd12;
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;

    // Accumulated string state; also carried to the date checker.
    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic               format_error;
        logic [DAY_W-1:0]   day_acc;
        logic [MONTH_W-1:0] month_acc;
        logic [YEAR_W-1:0]  year_acc;
        logic [1:0]         cc_mod4;   // century digits mod 4
        logic [1:0]         yy_mod4;   // low two year digits mod 4
        logic               yy_nz;     // low two year digits not both zero
    } scan_state_t;

    // Month length, Gregorian; zero for months that do not exist.
    function automatic logic [DAY_W-1:0] month_length(
        input logic [MONTH_W-1:0] m,
        input logic               leap
    );
        logic [DAY_W-1:0] len;
        len = '0;
        case (m)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 7'd31;
            7'd4, 7'd6, 7'd9, 7'd11:                    len = 7'd30;
            MONTH_FEB:                                  len = leap ? 7'd29 : 7'd28;
            default:                                    len = '0;
        endcase
        return len;
    endfunction

endpackage

// File: rtl/date_string_validator.sv
// Date string validator, DD.MM.YYYY.
// Input channel (in_valid/in_ready): one ASCII character per beat in ch,
// with last set on the final character of a string.
// Output channel (out_valid/out_ready): one beat per string, issued for the
// beat that carried last: valid_res plus the parsed day, month and year.
// Fields are zero when valid_res is low.
// Path: a character lands in the input register on acceptance and is
// scanned combinationally from there; for a last beat the verdict is
// loaded into the result register when the input register passes the beat
// on, which a held result can delay; out_valid comes from the result register.
// Throughput: one character per cycle while no last character waits behind a
// held result, set by the combinational scan and check logic between the registers.
// Stall: while the result register holds an untaken beat, a pending last
// character waits in the input register; other characters keep flowing.
// in_ready drops only when the input register holds such a waiting beat.
// Reset: rst_n clears the string position, flags and accumulators and
// empties both registers; the next character starts a new string.
module date_string_validator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [dsv_pkg::CH_W-1:0]    ch,
    input  logic                        last,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        valid_res,
    output logic [dsv_pkg::DAY_W-1:0]   day,
    output logic [dsv_pkg::MONTH_W-1:0] month,
    output logic [dsv_pkg::YEAR_W-1:0]  year
);

    // Input register
    logic                     s1_valid_reg;
    logic [dsv_pkg::CH_W-1:0] ch_reg;
    logic                     last_reg;

    // Result register
    logic                        res_valid_reg;
    logic                        ok_reg;
    logic [dsv_pkg::DAY_W-1:0]   day_reg;
    logic [dsv_pkg::MONTH_W-1:0] month_reg;
    logic [dsv_pkg::YEAR_W-1:0]  year_reg;

    logic in_fire;
    logic out_free;
    logic s1_fire;
    logic res_load;

    dsv_pkg::scan_state_t        state_next;
    logic                        ok_next;
    logic [dsv_pkg::DAY_W-1:0]   day_next;
    logic [dsv_pkg::MONTH_W-1:0] month_next;
    logic [dsv_pkg::YEAR_W-1:0]  year_next;

    assign out_free = !res_valid_reg || out_ready;
    // non-last beats never need the result slot
    assign s1_fire  = s1_valid_reg && (!last_reg || out_free);
    assign res_load = s1_fire && last_reg;
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ch_reg   <= ch;
            last_reg <= last;
        end
    end

    dsv_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (s1_fire),
        .ch         (ch_reg),
        .last       (last_reg),
        .state_next (state_next)
    );

    dsv_check u_check (
        .st    (state_next),
        .ok    (ok_next),
        .day   (day_next),
        .month (month_next),
        .year  (year_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            res_valid_reg <= res_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            ok_reg    <= ok_next;
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign valid_res = ok_reg;
    assign day       = day_reg;
    assign month     = month_reg;
    assign year      = year_reg;

    // A held result must not be overwritten by a waiting last beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !out_ready) |-> !res_load)
        else $error("result overwritten while stalled");

    // An invalid verdict carries zero fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !ok_reg) |-> (day_reg == '0 && month_reg == '0
                                        && year_reg == '0))
        else $error("invalid verdict with nonzero fields");

    // A valid verdict is within calendar bounds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && ok_reg) |-> (day_reg != '0 && day_reg <= 7'd31
            && month_reg != '0 && month_reg <= dsv_pkg::MONTH_MAX
            && year_reg != '0 && year_reg <= dsv_pkg::YEAR_MAX))
        else $error("valid verdict out of range");

    // A waiting input beat holds its character until scanned.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_fire) |=> (s1_valid_reg && $stable(ch_reg)
                                         && $stable(last_reg)))
        else $error("input register lost a waiting beat");

endmodule

// File: rtl/dsv_scan.sv
module dsv_scan (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      fire,
    input  logic [dsv_pkg::CH_W-1:0]  ch,
    input  logic                      last,
    output dsv_pkg::scan_state_t      state_next
);

    dsv_pkg::scan_state_t state_reg;
    dsv_pkg::scan_state_t upd;

    logic       is_digit;
    logic [3:0] dv;
    logic [dsv_pkg::POS_W-1:0] p;

    assign p        = state_reg.position;
    assign is_digit = (ch >= dsv_pkg::CH_ZERO) && (ch <= dsv_pkg::CH_NINE);
    assign dv       = is_digit ? 4'(ch - dsv_pkg::CH_ZERO) : 4'd0;

    always_comb
    begin
        upd = state_reg;
        if (p >= dsv_pkg::STRING_LEN)
        begin
            upd.format_error = 1'b1;
        end
        else if ((p == dsv_pkg::POS_DAY_END) || (p == dsv_pkg::POS_MONTH_END))
        begin
            if (ch != dsv_pkg::CH_DOT)
            begin
                upd.format_error = 1'b1;
            end
        end
        else if (!is_digit)
        begin
            upd.format_error = 1'b1;
        end
        else if (p < dsv_pkg::POS_DAY_END)
        begin
            upd.day_acc = 7'({state_reg.day_acc, 3'b000})
                        + 7'({state_reg.day_acc, 1'b0}) + 7'(dv);
        end
        else if (p < dsv_pkg::POS_MONTH_END)
        begin
            upd.month_acc = 7'({state_reg.month_acc, 3'b000})
                          + 7'({state_reg.month_acc, 1'b0}) + 7'(dv);
        end
        else
        begin
            upd.year_acc = 14'({state_reg.year_acc, 3'b000})
                         + 14'({state_reg.year_acc, 1'b0}) + 14'(dv);
            // x*10 + d == 2x + d (mod 4)
            if (p < dsv_pkg::POS_YY_LO)
            begin
                upd.cc_mod4 = {state_reg.cc_mod4[0], 1'b0} + dv[1:0];
            end
            else
            begin
                upd.yy_mod4 = {state_reg.yy_mod4[0], 1'b0} + dv[1:0];
                upd.yy_nz   = state_reg.yy_nz | (dv != 4'd0);
            end
        end
        if (p < dsv_pkg::POS_SAT)
        begin
            upd.position = p + 4'd1;
        end
    end

    assign state_next = upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (fire)
        begin
            state_reg <= last ? '0 : upd;
        end
    end

endmodule

// File: rtl/dsv_check.sv
module dsv_check (
    input  dsv_pkg::scan_state_t        st,
    output logic                        ok,
    output logic [dsv_pkg::DAY_W-1:0]   day,
    output logic [dsv_pkg::MONTH_W-1:0] month,
    output logic [dsv_pkg::YEAR_W-1:0]  year
);

    logic                      leap;
    logic [dsv_pkg::DAY_W-1:0] mlen;

    // Divisible by 4 and (not by 100, or by 400): with YY == 00 the
    // year is a multiple of 400 exactly when CC is a multiple of 4.
    assign leap = st.yy_nz ? (st.yy_mod4 == 2'd0) : (st.cc_mod4 == 2'd0);
    assign mlen = dsv_pkg::month_length(st.month_acc, leap);

    assign ok = !st.format_error
             && (st.position == dsv_pkg::STRING_LEN)
             && (st.year_acc != '0) && (st.year_acc <= dsv_pkg::YEAR_MAX)
             && (st.month_acc != '0) && (st.month_acc <= dsv_pkg::MONTH_MAX)
             && (st.day_acc != '0) && (st.day_acc <= mlen);

    assign day   = ok ? st.day_acc   : '0;
    assign month = ok ? st.month_acc : '0;
    assign year  = ok ? st.year_acc  : '0;

endmodule

// File: tb/sv/date_verdict_check.sv
`timescale 1ns / 1ps

module date_verdict_check
    import dsv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [CH_W-1:0]    ch,
    input  logic               last,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               valid_res,
    input  logic [DAY_W-1:0]   day,
    input  logic [MONTH_W-1:0] month,
    input  logic [YEAR_W-1:0]  year,
    output int                 fail_count,
    output int                 dates_owed
);

    typedef struct packed {
        logic               ok;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } verdict_t;

    verdict_t expected_dates[$];

    // mirror of the scan state
    logic [POS_W-1:0]   scan_pos;
    logic               bad_layout;
    logic [DAY_W-1:0]   day_sum;
    logic [MONTH_W-1:0] month_sum;
    logic [YEAR_W-1:0]  year_sum;

    initial fail_count = 0;
    initial dates_owed = 0;

    function automatic int unsigned days_in(input int unsigned m, input int unsigned y);
        logic leap;
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        case (m)
            2:             return leap ? 29 : 28;
            4, 6, 9, 11:   return 30;
            1, 3, 5, 7, 8, 10, 12: return 31;
            default:       return 0;
        endcase
    endfunction

    function automatic void clear_scan();
        scan_pos   = '0;
        bad_layout = 1'b0;
        day_sum    = '0;
        month_sum  = '0;
        year_sum   = '0;
    endfunction

    function automatic void scan_char(input logic [CH_W-1:0] c, input logic fin);
        logic        digit;
        int unsigned dv;
        verdict_t    v;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        dv    = digit ? int'(c - CH_ZERO) : 0;
        if (scan_pos >= STRING_LEN)
            bad_layout = 1'b1;
        else if (scan_pos == POS_DAY_END || scan_pos == POS_MONTH_END)
        begin
            if (c != CH_DOT)
                bad_layout = 1'b1;
        end
        else if (!digit)
            bad_layout = 1'b1;
        else if (scan_pos < POS_DAY_END)
            day_sum = DAY_W'(day_sum * 10 + dv);
        else if (scan_pos < POS_MONTH_END)
            month_sum = MONTH_W'(month_sum * 10 + dv);
        else
            year_sum = YEAR_W'(year_sum * 10 + dv);
        if (scan_pos < POS_SAT)
            scan_pos = scan_pos + 1'b1;
        if (fin)
        begin
            v.ok = !bad_layout && scan_pos == STRING_LEN
                && year_sum >= 1 && year_sum <= YEAR_MAX
                && month_sum >= 1 && month_sum <= MONTH_MAX
                && day_sum >= 1 && day_sum <= days_in(month_sum, year_sum);
            v.day   = v.ok ? day_sum : '0;
            v.month = v.ok ? month_sum : '0;
            v.year  = v.ok ? year_sum : '0;
            expected_dates.push_back(v);
            clear_scan();
        end
    endfunction

    always @(posedge clk)
    begin : watch
        verdict_t want;
        if (!rst_n)
        begin
            clear_scan();
            expected_dates.delete();
            dates_owed <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_dates.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result beat with none expected: ok=%0d %0d.%0d.%0d",
                                 $realtime, valid_res, day, month, year);
                end
                else
                begin
                    want = expected_dates.pop_front();
                    if (want.ok != valid_res || want.day != day
                        || want.month != month || want.year != year)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: result mismatch exp ok=%0d %0d.%0d.%0d got ok=%0d %0d.%0d.%0d",
                                     $realtime, want.ok, want.day, want.month, want.year,
                                     valid_res, day, month, year);
                    end
                end
            end
            if (in_valid && in_ready)
                scan_char(ch, last);
            dates_owed <= expected_dates.size();
        end
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import dsv_pkg::*;

    // Cycles with no beat on either channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Settling time after the last result.
    localparam int DRAIN_CYCLES   = 10;
    localparam int TARGET_CHARS   = 1300;
    // Window of characters with no idling on either side.
    localparam int STEADY_FROM    = 500;
    localparam int STEADY_TO      = 750;

    typedef logic [CH_W-1:0] char_q_t[$];

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic [CH_W-1:0]    ch        = '0;
    logic               last      = 1'b0;
    logic               out_ready = 1'b0;
    logic               in_ready;
    logic               out_valid;
    logic               valid_res;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;

    int   fail_count;
    int   dates_owed;
    int   chars_sent = 0;
    int   quiet_cycles = 0;
    logic steady = 1'b0;    // high while neither side may idle

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    date_string_validator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .ch        (ch),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .valid_res (valid_res),
        .day       (day),
        .month     (month),
        .year      (year)
    );

    // Predicts the verdict of every string and compares result beats.
    date_verdict_check checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .ch         (ch),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .valid_res  (valid_res),
        .day        (day),
        .month      (month),
        .year       (year),
        .fail_count (fail_count),
        .dates_owed (dates_owed)
    );

    // Receiver: stalls about 13% of cycles, never inside the steady window.
    always @(posedge clk)
        out_ready <= steady || ($urandom_range(99) >= 13);

    // Watchdog: any beat on either side restarts the count.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("date_string_validator verification failed");
            $finish;
        end
    end

    function automatic logic [CH_W-1:0] digit_char(input int unsigned n);
        return CH_ZERO + CH_W'(n % 10);
    endfunction

    // DD.MM.YYYY text for any field values; fields wider than the slot wrap.
    function automatic char_q_t date_text(input int unsigned d, input int unsigned m,
                                          input int unsigned y);
        char_q_t s;
        s.push_back(digit_char(d / 10));
        s.push_back(digit_char(d));
        s.push_back(CH_DOT);
        s.push_back(digit_char(m / 10));
        s.push_back(digit_char(m));
        s.push_back(CH_DOT);
        s.push_back(digit_char(y / 1000));
        s.push_back(digit_char(y / 100));
        s.push_back(digit_char(y / 10));
        s.push_back(digit_char(y));
        return s;
    endfunction

    // Well-formed layout, with fields biased toward the calendar edges:
    // century years, leap multiples, year 0 / 9999, day 28..32, Feb.
    function automatic char_q_t random_date();
        int unsigned d, m, y;
        case ($urandom_range(9))
            0, 1, 2, 3: y = $urandom_range(1, 9999);
            4:          y = 400 * $urandom_range(1, 24);
            5:          y = 100 * $urandom_range(1, 99);
            6:          y = 4 * $urandom_range(1, 2499);
            7:          y = ($urandom_range(2) == 0) ? 0 : (($urandom_range(1) == 0) ? 1 : 9999);
            default:    y = $urandom_range(0, 9999);
        endcase
        if ($urandom_range(3) == 0)
            m = 2;
        else if ($urandom_range(99) < 85)
            m = $urandom_range(1, 12);
        else
            m = $urandom_range(0, 99);
        case ($urandom_range(9))
            0, 1, 2, 3, 4: d = $urandom_range(1, 28);
            5, 6, 7:       d = $urandom_range(28, 32);
            8:             d = 0;
            default:       d = $urandom_range(0, 99);
        endcase
        return date_text(d, m, y);
    endfunction

    // One character beat; idles first unless in the steady window.
    task automatic push_char(input logic [CH_W-1:0] c, input logic fin);
        while (!steady && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ch       <= c;
        last     <= fin;
        do
            @(posedge clk);
        while (!in_ready);
        chars_sent++;
    endtask

    task automatic push_string(input char_q_t s);
        for (int i = 0; i < s.size(); i++)
            push_char(s[i], i == s.size() - 1);
    endtask

    // Hold the sender until every expected verdict has been taken.
    task automatic wait_all_taken();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (dates_owed != 0);
    endtask

    initial
    begin : stimulus
        char_q_t s;
        int      n;
        logic    paused;
        paused = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: leap day of a 400-multiple year, June 31st at the top
        // year, a one-character string of 0xFF, and a short string of 0x00 + dot.
        push_string(date_text(29, 2, 2000));
        push_string(date_text(31, 6, 9999));
        s = {};
        s.push_back(8'hFF);
        push_string(s);
        s = {};
        s.push_back(8'h00);
        s.push_back(CH_DOT);
        push_string(s);
        wait_all_taken();

        while (chars_sent < TARGET_CHARS)
        begin
            // One forced drain as the steady window opens.
            if (!paused && chars_sent >= STEADY_FROM)
            begin
                wait_all_taken();
                paused = 1'b1;
            end
            steady <= (chars_sent >= STEADY_FROM) && (chars_sent < STEADY_TO);

            n = $urandom_range(99);
            if (n < 60)
                s = random_date();
            else if (n < 72)
            begin
                // one character overwritten somewhere in the layout
                s = random_date();
                case ($urandom_range(3))
                    0:       s[$urandom_range(9)] = CH_ZERO - CH_W'(1);
                    1:       s[$urandom_range(9)] = CH_NINE + CH_W'(1);
                    2:       s[$urandom_range(9)] = CH_DOT;
                    default: s[$urandom_range(9)] = CH_W'($urandom_range(255));
                endcase
            end
            else if (n < 82)
            begin
                // marked last before the tenth character
                s = random_date();
                n = $urandom_range(1, 9);
                while (s.size() > n)
                    void'(s.pop_back());
            end
            else if (n < 92)
            begin
                // overlong; some run far enough to test position saturation
                s = random_date();
                n = ($urandom_range(3) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 5);
                repeat (n)
                    s.push_back(($urandom_range(1) == 0) ? digit_char($urandom_range(9))
                                                         : CH_W'($urandom_range(255)));
            end
            else
            begin
                // raw noise
                s = {};
                repeat ($urandom_range(1, 14))
                    s.push_back(CH_W'($urandom_range(255)));
            end
            push_string(s);
        end

        steady <= 1'b0;
        wait_all_taken();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("date_string_validator verification clean");
        else
            $display("date_string_validator verification failed");
        $finish;
    end

endmodule
